// ===== hw/rtl/htfd_pkg.sv =====
// Package with shared types, constants and functions of the sensor frame decoder.
package htfd_pkg;

    localparam int unsigned CrcPoly = 8'h31;
    localparam int unsigned TempSpan = 16500;
    localparam int unsigned TempOffset = 4000;
    localparam int unsigned HumidSpan = 10000;
    localparam int unsigned HumidMax = 10000;
    localparam int unsigned TempMax = 12500;

    localparam logic [2:0] POS_TEMP_HI = 3'd0;
    localparam logic [2:0] POS_TEMP_LO = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUMID_HI = 3'd3;
    localparam logic [2:0] POS_HUMID_LO = 3'd4;
    localparam logic [2:0] POS_HUMID_CRC = 3'd5;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
    localparam logic [1:0] STATUS_HUMID_CRC = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } htfd_in_t;

    typedef struct packed {
        logic signed [14:0] temp_centi_deg;
        logic [13:0]        humid_centi_pct;
        logic [1:0]         status;
    } htfd_out_t;

    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
        logic [1:0]  status;
    } htfd_frame_t;

    // CRC-8, MSB first, one byte folded in.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ 8'(CrcPoly);
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Floor division by 65535 for values below 65535 * 65536 (quotient fits in 16 bits), without a divider.
    function automatic logic [15:0] div65535(input logic [31:0] p);
        logic [32:0] sum;
        sum = {1'b0, p} + {17'd0, p[31:16]} + 33'd1;
        return sum[31:16];
    endfunction

endpackage

// ===== hw/rtl/humidity_temp_frame_decoder_core.sv =====
// Top level of the humidity and temperature sensor frame decoder.
//
//   channel   signals                                       beat
//   sensor    sensor_valid, sensor_ready, sensor_data       one frame byte
//   result    result_valid, result_ready, result_data       one decoded frame
//
// A byte beat can be taken in every cycle unless the output stalls; the sixth
// byte of a frame yields a result beat through the finished-frame register
// and the result register.
// Reset clears the byte count, the CRC and both valid registers.
// A stalled result holds the result register and then the finished-frame
// register; sensor_ready drops only while both are full.
module humidity_temp_frame_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sensor_valid,
    output logic                sensor_ready,
    input  htfd_pkg::htfd_in_t  sensor_data,
    output logic                result_valid,
    input  logic                result_ready,
    output htfd_pkg::htfd_out_t result_data
);

    logic                  done_valid;
    logic                  done_ready;
    htfd_pkg::htfd_frame_t done_data;

    htfd_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .sensor_valid (sensor_valid),
        .sensor_ready (sensor_ready),
        .sensor_data  (sensor_data),
        .done_valid   (done_valid),
        .done_ready   (done_ready),
        .done_data    (done_data)
    );

    htfd_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .done_valid   (done_valid),
        .done_ready   (done_ready),
        .done_data    (done_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

// ===== hw/rtl/htfd_frame.sv =====
// Byte tracker: frame position, running CRC, raw words and the finished-frame register.
module htfd_frame (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sensor_valid,
    output logic                 sensor_ready,
    input  htfd_pkg::htfd_in_t   sensor_data,
    output logic                 done_valid,
    input  logic                 done_ready,
    output htfd_pkg::htfd_frame_t done_data
);

    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [7:0]  crc_reg;
    logic [7:0]  crc_next;
    logic        temp_bad_reg;
    logic        temp_bad_next;
    logic [15:0] temp_hold_reg;
    logic [15:0] temp_hold_next;
    logic [15:0] humid_hold_reg;
    logic [15:0] humid_hold_next;
    logic        done_valid_reg;
    logic        done_valid_next;
    htfd_pkg::htfd_frame_t done_reg;
    htfd_pkg::htfd_frame_t done_next;

    logic       take;
    logic [2:0] pos;
    logic [7:0] crc_base;
    logic [7:0] crc_step;

    assign sensor_ready = !done_valid_reg || done_ready;
    assign take = sensor_valid && sensor_ready;
    assign done_valid = done_valid_reg;
    assign done_data = done_reg;

    always_comb
    begin
        if (sensor_data.frame_start || count_reg > htfd_pkg::POS_HUMID_CRC)
        begin
            pos = htfd_pkg::POS_TEMP_HI;
        end
        else
        begin
            pos = count_reg;
        end
        if (pos == htfd_pkg::POS_TEMP_LO || pos == htfd_pkg::POS_HUMID_LO)
        begin
            crc_base = crc_reg;
        end
        else
        begin
            crc_base = 8'd0;
        end
        crc_step = htfd_pkg::crc8_byte(crc_base, sensor_data.rx_byte);
    end

    always_comb
    begin
        count_next = count_reg;
        crc_next = crc_reg;
        temp_bad_next = temp_bad_reg;
        temp_hold_next = temp_hold_reg;
        humid_hold_next = humid_hold_reg;
        done_next = done_reg;
        done_valid_next = done_valid_reg && !done_ready;
        if (take)
        begin
            if (pos == htfd_pkg::POS_HUMID_CRC)
            begin
                count_next = htfd_pkg::POS_TEMP_HI;
            end
            else
            begin
                count_next = pos + 3'd1;
            end
            case (pos)
                htfd_pkg::POS_TEMP_HI:
                begin
                    temp_hold_next = {sensor_data.rx_byte, 8'd0};
                    crc_next = crc_step;
                end
                htfd_pkg::POS_TEMP_LO:
                begin
                    temp_hold_next = {temp_hold_reg[15:8], sensor_data.rx_byte};
                    crc_next = crc_step;
                end
                htfd_pkg::POS_TEMP_CRC:
                begin
                    temp_bad_next = crc_reg != sensor_data.rx_byte;
                    crc_next = 8'd0;
                end
                htfd_pkg::POS_HUMID_HI:
                begin
                    humid_hold_next = {sensor_data.rx_byte, 8'd0};
                    crc_next = crc_step;
                end
                htfd_pkg::POS_HUMID_LO:
                begin
                    humid_hold_next = {humid_hold_reg[15:8], sensor_data.rx_byte};
                    crc_next = crc_step;
                end
                default:
                begin
                    crc_next = 8'd0;
                    done_valid_next = 1'b1;
                    done_next.temp_raw = temp_hold_reg;
                    done_next.humid_raw = humid_hold_reg;
                    if (temp_bad_reg)
                    begin
                        done_next.status = htfd_pkg::STATUS_TEMP_CRC;
                    end
                    else if (crc_reg != sensor_data.rx_byte)
                    begin
                        done_next.status = htfd_pkg::STATUS_HUMID_CRC;
                    end
                    else
                    begin
                        done_next.status = htfd_pkg::STATUS_OK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= htfd_pkg::POS_TEMP_HI;
            crc_reg <= 8'd0;
            temp_bad_reg <= 1'b0;
            done_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg <= crc_next;
            temp_bad_reg <= temp_bad_next;
            done_valid_reg <= done_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_hold_reg <= temp_hold_next;
        humid_hold_reg <= humid_hold_next;
        done_reg <= done_next;
    end

endmodule

// ===== hw/rtl/htfd_scale.sv =====
// Scaling of the raw words to hundredths and the result register.
module htfd_scale (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  done_valid,
    output logic                  done_ready,
    input  htfd_pkg::htfd_frame_t done_data,
    output logic                  result_valid,
    input  logic                  result_ready,
    output htfd_pkg::htfd_out_t   result_data
);

    logic                result_valid_reg;
    logic                result_valid_next;
    htfd_pkg::htfd_out_t result_reg;
    htfd_pkg::htfd_out_t result_next;

    logic [30:0] temp_prod;
    logic [29:0] humid_prod;
    logic [15:0] temp_q;
    logic [15:0] humid_q;
    logic [15:0] temp_diff;

    assign done_ready = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result_data = result_reg;

    always_comb
    begin
        temp_prod = 31'(done_data.temp_raw) * 31'(htfd_pkg::TempSpan);
        humid_prod = 30'(done_data.humid_raw) * 30'(htfd_pkg::HumidSpan);
        temp_q = htfd_pkg::div65535({1'b0, temp_prod});
        humid_q = htfd_pkg::div65535({2'b00, humid_prod});
        temp_diff = temp_q - 16'(htfd_pkg::TempOffset);
    end

    always_comb
    begin
        result_next = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (done_valid && done_ready)
        begin
            result_valid_next = 1'b1;
            result_next.status = done_data.status;
            if (done_data.status == htfd_pkg::STATUS_OK)
            begin
                result_next.temp_centi_deg = $signed(temp_diff[14:0]);
                result_next.humid_centi_pct = humid_q[13:0];
            end
            else
            begin
                result_next.temp_centi_deg = 15'sd0;
                result_next.humid_centi_pct = 14'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ===== hw/rtl/htfd_checker.sv =====
// Port-level checker for the frame decoder and its bind to the top level.
module htfd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                sensor_valid,
    input logic                sensor_ready,
    input logic                result_valid,
    input logic                result_ready,
    input htfd_pkg::htfd_out_t result_data
);

    logic sensor_take;

    assign sensor_take = sensor_valid && sensor_ready;

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result beat changed while stalled");

    // Error results carry zero values, and the status is one of the three codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.status == htfd_pkg::STATUS_OK) ||
            ((result_data.status == htfd_pkg::STATUS_TEMP_CRC ||
              result_data.status == htfd_pkg::STATUS_HUMID_CRC) &&
             result_data.temp_centi_deg == 15'sd0 && result_data.humid_centi_pct == 14'd0))
    else $error("bad status or nonzero values on an error result");

    // Good results stay within the sensor's range.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status == htfd_pkg::STATUS_OK |->
            result_data.humid_centi_pct <= 14'(htfd_pkg::HumidMax) &&
            result_data.temp_centi_deg >= -15'sd4000 &&
            result_data.temp_centi_deg <= $signed(15'(htfd_pkg::TempMax)))
    else $error("scaled value out of range");

    // A new result follows the closing byte via the finished-frame register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sensor_take, 2))
    else $error("result appeared without a closing byte");

    // With the output empty the input side is never stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sensor_ready)
    else $error("sensor_ready low while the output is empty");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sensor_valid (sensor_valid),
    .sensor_ready (sensor_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);

// ===== dv/humidity_temp_frame_decoder_core_tb.sv =====
// Self-checking testbench for the sensor frame decoder core: frame bytes in, readings checked.
module humidity_temp_frame_decoder_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                sensor_valid = 1'b0;
    logic                sensor_ready;
    htfd_pkg::htfd_in_t  sensor_data = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    htfd_pkg::htfd_out_t result_data;

    logic [2:0]  frame_pos = '0;
    logic [7:0]  crc_acc = '0;
    logic [15:0] temp_word = '0;
    logic [15:0] humid_word = '0;
    logic        temp_bad = 1'b0;

    htfd_pkg::htfd_out_t pending_readings[$];
    int        mismatches = 0;
    int        readings_seen = 0;
    int        bytes_sent = 0;
    bit        steady_flow = 1'b0;

    humidity_temp_frame_decoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sensor_valid (sensor_valid),
        .sensor_ready (sensor_ready),
        .sensor_data  (sensor_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("humidity_temp_frame_decoder_core: mismatch");
        $finish;
    end

    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0};
            if (fb)
            begin
                c = c ^ 8'(htfd_pkg::CrcPoly);
            end
        end
        return c;
    endfunction

    function automatic void take_byte(input logic [7:0] b, input logic fs);
        htfd_pkg::htfd_out_t r;
        logic [2:0]  p;
        int unsigned tq;
        if (fs)
        begin
            frame_pos = htfd_pkg::POS_TEMP_HI;
            crc_acc = '0;
        end
        p = (frame_pos > htfd_pkg::POS_HUMID_CRC) ? htfd_pkg::POS_TEMP_HI : frame_pos;
        case (p)
            htfd_pkg::POS_TEMP_HI:
            begin
                temp_word = {b, 8'h00};
                crc_acc = crc8_fold(8'h00, b);
            end
            htfd_pkg::POS_TEMP_LO:
            begin
                temp_word[7:0] = b;
                crc_acc = crc8_fold(crc_acc, b);
            end
            htfd_pkg::POS_TEMP_CRC:
            begin
                temp_bad = (crc_acc != b);
                crc_acc = '0;
            end
            htfd_pkg::POS_HUMID_HI:
            begin
                humid_word = {b, 8'h00};
                crc_acc = crc8_fold(8'h00, b);
            end
            htfd_pkg::POS_HUMID_LO:
            begin
                humid_word[7:0] = b;
                crc_acc = crc8_fold(crc_acc, b);
            end
            default:
            begin
                r = '0;
                if (temp_bad)
                begin
                    r.status = htfd_pkg::STATUS_TEMP_CRC;
                end
                else if (crc_acc != b)
                begin
                    r.status = htfd_pkg::STATUS_HUMID_CRC;
                end
                else
                begin
                    r.status = htfd_pkg::STATUS_OK;
                    tq = (int'(temp_word) * htfd_pkg::TempSpan) / 65535;
                    r.temp_centi_deg = 15'(int'(tq) - int'(htfd_pkg::TempOffset));
                    r.humid_centi_pct =
                        14'((int'(humid_word) * htfd_pkg::HumidSpan) / 65535);
                end
                pending_readings.push_back(r);
                crc_acc = '0;
            end
        endcase
        frame_pos = (p >= htfd_pkg::POS_HUMID_CRC) ? htfd_pkg::POS_TEMP_HI : p + 3'd1;
    endfunction

    function automatic void check_reading(input htfd_pkg::htfd_out_t got);
        htfd_pkg::htfd_out_t want;
        readings_seen++;
        if (pending_readings.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("reading %0d: unexpected beat temp %0d humid %0d status %0d",
                         readings_seen, got.temp_centi_deg, got.humid_centi_pct, got.status);
            end
            return;
        end
        want = pending_readings.pop_front();
        if (got.temp_centi_deg !== want.temp_centi_deg
            || got.humid_centi_pct !== want.humid_centi_pct
            || got.status !== want.status)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("reading %0d: expected temp %0d humid %0d status %0d, got %0d %0d %0d",
                         readings_seen, want.temp_centi_deg, want.humid_centi_pct, want.status,
                         got.temp_centi_deg, got.humid_centi_pct, got.status);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            check_reading(result_data);
        end
        result_ready <= steady_flow || ($urandom_range(99) >= 22);
    end

    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = 0;
        if (!steady_flow)
        begin
            while ($urandom_range(99) < 22)
            begin
                gap++;
            end
        end
        if (gap > 0)
        begin
            sensor_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sensor_valid <= 1'b1;
        sensor_data <= '{rx_byte: b, frame_start: fs};
        do @(posedge clk); while (!sensor_ready);
        take_byte(b, fs);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic fs,
                              input logic spoil_t, input logic spoil_h);
        logic [7:0] tc;
        logic [7:0] hc;
        tc = crc8_fold(crc8_fold(8'h00, t[15:8]), t[7:0]);
        hc = crc8_fold(crc8_fold(8'h00, h[15:8]), h[7:0]);
        if (spoil_t)
        begin
            tc = tc ^ 8'($urandom_range(255, 1));
        end
        if (spoil_h)
        begin
            hc = hc ^ 8'($urandom_range(255, 1));
        end
        send_byte(t[15:8], fs);
        send_byte(t[7:0], 1'b0);
        send_byte(tc, 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(hc, 1'b0);
    endtask

    task automatic drain_readings();
        sensor_valid <= 1'b0;
        do @(posedge clk); while (pending_readings.size() != 0);
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(65535 - $urandom_range(15));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic test_scaling_extremes();
        send_frame(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_crc_errors();
        send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_frame_restart();
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_frame(16'h6666, 16'h9999, 1'b1, 1'b0, 1'b1);
    endtask

    task automatic test_drain_pause();
        send_frame(pick_raw(), pick_raw(), 1'b1, 1'b0, 1'b0);
        drain_readings();
        send_frame(pick_raw(), pick_raw(), 1'b0, 1'b0, 1'b0);
    endtask

    task automatic run_mixed_traffic(input int item_goal);
        bit after_noise;
        int noise_len;
        after_noise = 1'b1;
        while (bytes_sent < item_goal)
        begin
            if ($urandom_range(99) < 85)
            begin
                send_frame(pick_raw(), pick_raw(),
                           after_noise ? 1'b1 : 1'($urandom_range(1)),
                           $urandom_range(9) == 0, $urandom_range(9) == 0);
                after_noise = 1'b0;
            end
            else
            begin
                noise_len = $urandom_range(5, 1);
                repeat (noise_len)
                begin
                    send_byte(8'($urandom_range(255)), $urandom_range(99) < 30);
                end
                after_noise = 1'b1;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_mixed_traffic(bytes_sent + 800);
    endtask

    task automatic test_steady_stream();
        steady_flow = 1'b1;
        run_mixed_traffic(bytes_sent + 200);
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_scaling_extremes();
        test_crc_errors();
        test_frame_restart();
        test_drain_pause();
        test_random_traffic();
        test_steady_stream();
        drain_readings();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_readings.size() == 0)
        begin
            $display("humidity_temp_frame_decoder_core: match");
        end
        else
        begin
            $display("humidity_temp_frame_decoder_core: mismatch");
        end
        $finish;
    end

endmodule
